>>> rtl/core/lcsb_pkg.sv
package lcsb_pkg;

   localparam int STORE_DEPTH_DEFAULT = 256;
   localparam int WINDOW_COLUMNS      = 8;
   localparam int COL_IDX_W           = $clog2(WINDOW_COLUMNS);
   localparam int BYTE_W              = 8;
   localparam int SPEED_W             = 4;
   localparam int DIGIT_W             = 4;
   localparam int FILL_W              = 9;
   localparam int CSR_INDEX_W         = 8;
   localparam int CSR_DATA_W          = 8;

   localparam logic [BYTE_W-1:0]  THRESHOLD_RESET = 8'd20;
   localparam logic [SPEED_W-1:0] SPEED_RESET     = 4'd15;
   localparam logic [BYTE_W-1:0]  BLANK_COLUMN    = 8'h00;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CHAR_THRESHOLD = 8'd0,
      REG_SPEED_BASE     = 8'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_FRAME
   } state_type;

   typedef logic [BYTE_W-1:0] column_type;

endpackage

>>> rtl/core/lcsb_channels.sv
interface lcsb_req_if;
   logic                     valid;
   logic                     ready;
   logic                     op;
   lcsb_pkg::column_type     rx_byte;
   lcsb_pkg::column_type     glyph_col0;
   lcsb_pkg::column_type     glyph_col1;
   lcsb_pkg::column_type     glyph_col2;
   lcsb_pkg::column_type     glyph_col3;
   lcsb_pkg::column_type     glyph_col4;
   lcsb_pkg::column_type     glyph_col5;
   lcsb_pkg::column_type     glyph_col6;
   lcsb_pkg::column_type     glyph_col7;

   modport source (
      output valid, op, rx_byte, glyph_col0, glyph_col1, glyph_col2, glyph_col3,
             glyph_col4, glyph_col5, glyph_col6, glyph_col7,
      input  ready
   );
   modport sink (
      input  valid, op, rx_byte, glyph_col0, glyph_col1, glyph_col2, glyph_col3,
             glyph_col4, glyph_col5, glyph_col6, glyph_col7,
      output ready
   );
endinterface

interface lcsb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lcsb_pkg::DIGIT_W-1:0]        digit_index;
   lcsb_pkg::column_type                column_bits;
   logic                                last;
   logic [lcsb_pkg::FILL_W-1:0]         fill_level;

   modport source (
      output valid, digit_index, column_bits, last, fill_level,
      input  ready
   );
   modport sink (
      input  valid, digit_index, column_bits, last, fill_level,
      output ready
   );
endinterface

interface lcsb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lcsb_pkg::CSR_INDEX_W-1:0]    index;
   logic [lcsb_pkg::CSR_DATA_W-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

>>> rtl/core/led_column_scroll_buffer_core.sv
// Glyph column FIFO for an eight-column LED matrix. A received byte at or
// above char_threshold queues the eight glyph columns of its beat (dropped
// whole if fewer than eight places are free); a lower byte sets the frame
// period to speed_base minus the byte, floored at zero. A tick beat either
// advances the tick counter or, once it has reached the period, emits a
// frame of eight rsp beats (digits 1..8, columns padded with zero) and pops
// one column if any is stored. Columns live in a single STORE_DEPTH x 8
// memory with one write and one registered read port; one req beat is
// worked at a time. Speed codes, ticks without a frame and dropped
// characters end with the accept. A character is the accept plus eight
// writes on the write port. A frame is the accept plus eight reads on the
// read port at one per cycle while rsp does not stall. The last rsp beat
// may still wait in the output register while the next req beat is taken.
module led_column_scroll_buffer_core #(
   parameter int STORE_DEPTH = lcsb_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   lcsb_req_if.sink         req_bus,
   lcsb_rsp_if.source       rsp_bus,
   lcsb_csr_if.sink         csr_bus
);

   localparam int AW   = $clog2(STORE_DEPTH);
   localparam int CW   = $clog2(STORE_DEPTH + 1);
   localparam int CIW  = lcsb_pkg::COL_IDX_W;
   localparam int WIN  = lcsb_pkg::WINDOW_COLUMNS;

   // configuration
   lcsb_pkg::column_type              thr_ff;
   logic [lcsb_pkg::SPEED_W-1:0]      base_ff;

   // scroll state
   lcsb_pkg::state_type               state_ff, state_in;
   logic [lcsb_pkg::SPEED_W-1:0]      period_ff, period_in;
   logic [lcsb_pkg::SPEED_W-1:0]      tick_ff, tick_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [AW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     count_ff, count_in;

   // character write
   lcsb_pkg::column_type              glyph_ff [WIN];
   lcsb_pkg::column_type              glyph_in [WIN];
   logic [CIW-1:0]                    wr_cnt_ff, wr_cnt_in;

   // frame read
   logic [CIW:0]                      iss_cnt_ff, iss_cnt_in;
   logic [AW-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [CIW-1:0]                    rd_idx_ff, rd_idx_in;
   logic                              rd_pad_ff, rd_pad_in;
   lcsb_pkg::column_type              rd_data_ff;

   // output register
   logic                              out_valid_ff, out_valid_in;
   logic [lcsb_pkg::DIGIT_W-1:0]      out_digit_ff, out_digit_in;
   lcsb_pkg::column_type              out_bits_ff, out_bits_in;
   logic                              out_last_ff, out_last_in;
   logic [lcsb_pkg::FILL_W-1:0]       out_fill_ff, out_fill_in;

   lcsb_pkg::column_type              mem [STORE_DEPTH];

   logic req_fire, is_char, has_room, fires, push_go, frame_go;
   logic mem_we, mem_re, load, frame_done, push_done;

   // control decode
   always_comb begin
      req_bus.ready = (state_ff == lcsb_pkg::ST_IDLE);
      csr_bus.ready = 1'b1;
      req_fire      = req_bus.valid && req_bus.ready;
      is_char       = (req_bus.rx_byte >= thr_ff);
      has_room      = ({1'b0, count_ff} + (CW+1)'(WIN)) <= (CW+1)'(STORE_DEPTH);
      fires         = (tick_ff >= period_ff);
      push_go       = req_fire && (req_bus.op == lcsb_pkg::OP_BYTE) && is_char && has_room;
      frame_go      = req_fire && (req_bus.op == lcsb_pkg::OP_TICK) && fires;
      mem_we        = (state_ff == lcsb_pkg::ST_PUSH);
      push_done     = mem_we && (wr_cnt_ff == CIW'(WIN - 1));
      load          = rd_valid_ff && (!out_valid_ff || rsp_bus.ready);
      mem_re        = (state_ff == lcsb_pkg::ST_FRAME) && (iss_cnt_ff < (CIW+1)'(WIN))
                      && (!rd_valid_ff || load);
      frame_done    = load && (rd_idx_ff == CIW'(WIN - 1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcsb_pkg::ST_IDLE: begin
            if (push_go) begin
               state_in = lcsb_pkg::ST_PUSH;
            end else if (frame_go) begin
               state_in = lcsb_pkg::ST_FRAME;
            end
         end
         lcsb_pkg::ST_PUSH: begin
            if (push_done) begin
               state_in = lcsb_pkg::ST_IDLE;
            end
         end
         lcsb_pkg::ST_FRAME: begin
            if (frame_done) begin
               state_in = lcsb_pkg::ST_IDLE;
            end
         end
         default: state_in = lcsb_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      period_in    = period_ff;
      tick_in      = tick_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      glyph_in     = glyph_ff;
      wr_cnt_in    = wr_cnt_ff;
      iss_cnt_in   = iss_cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_valid_in  = rd_valid_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pad_in    = rd_pad_ff;
      out_valid_in = out_valid_ff;
      out_digit_in = out_digit_ff;
      out_bits_in  = out_bits_ff;
      out_last_in  = out_last_ff;
      out_fill_in  = out_fill_ff;

      if (req_fire) begin
         if (req_bus.op == lcsb_pkg::OP_BYTE) begin
            if (!is_char) begin
               period_in = ({4'd0, base_ff} > req_bus.rx_byte)
                           ? base_ff - req_bus.rx_byte[lcsb_pkg::SPEED_W-1:0] : '0;
            end
         end else if (fires) begin
            tick_in = '0;
         end else begin
            tick_in = tick_ff + 1'b1;
         end
      end

      if (push_go) begin
         glyph_in[0] = req_bus.glyph_col0;
         glyph_in[1] = req_bus.glyph_col1;
         glyph_in[2] = req_bus.glyph_col2;
         glyph_in[3] = req_bus.glyph_col3;
         glyph_in[4] = req_bus.glyph_col4;
         glyph_in[5] = req_bus.glyph_col5;
         glyph_in[6] = req_bus.glyph_col6;
         glyph_in[7] = req_bus.glyph_col7;
         wr_cnt_in   = '0;
      end

      if (mem_we) begin
         for (int i = 0; i < WIN - 1; i++) begin
            glyph_in[i] = glyph_ff[i+1];
         end
         wr_cnt_in = wr_cnt_ff + 1'b1;
         tail_in   = (tail_ff == AW'(STORE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         if (push_done) begin
            count_in = count_ff + CW'(WIN);
         end
      end

      if (frame_go) begin
         iss_cnt_in  = '0;
         rd_ptr_in   = head_ff;
         rd_valid_in = 1'b0;
      end

      if (load) begin
         out_valid_in = 1'b1;
         out_digit_in = lcsb_pkg::DIGIT_W'(rd_idx_ff) + 1'b1;
         out_bits_in  = rd_pad_ff ? lcsb_pkg::BLANK_COLUMN : rd_data_ff;
         out_last_in  = (rd_idx_ff == CIW'(WIN - 1));
         out_fill_in  = lcsb_pkg::FILL_W'(count_ff);
         rd_valid_in  = 1'b0;
      end else if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (mem_re) begin
         iss_cnt_in  = iss_cnt_ff + 1'b1;
         rd_ptr_in   = (rd_ptr_ff == AW'(STORE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         rd_valid_in = 1'b1;
         rd_idx_in   = iss_cnt_ff[CIW-1:0];
         rd_pad_in   = (CW'(iss_cnt_ff) >= count_ff);
      end

      if (frame_done && (count_ff != '0)) begin
         head_in  = (head_ff == AW'(STORE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_bus.valid       = out_valid_ff;
      rsp_bus.digit_index = out_digit_ff;
      rsp_bus.column_bits = out_bits_ff;
      rsp_bus.last        = out_last_ff;
      rsp_bus.fill_level  = out_fill_ff;
   end

   // column store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= glyph_ff[0];
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= lcsb_pkg::THRESHOLD_RESET;
         base_ff <= lcsb_pkg::SPEED_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            lcsb_pkg::REG_CHAR_THRESHOLD: thr_ff  <= csr_bus.data;
            lcsb_pkg::REG_SPEED_BASE:     base_ff <= csr_bus.data[lcsb_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcsb_pkg::ST_IDLE;
         period_ff    <= lcsb_pkg::SPEED_RESET;
         tick_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         wr_cnt_ff    <= '0;
         iss_cnt_ff   <= '0;
         rd_ptr_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         tick_ff      <= tick_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         wr_cnt_ff    <= wr_cnt_in;
         iss_cnt_ff   <= iss_cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      rd_idx_ff    <= rd_idx_in;
      rd_pad_ff    <= rd_pad_in;
      out_digit_ff <= out_digit_in;
      out_bits_ff  <= out_bits_in;
      out_last_ff  <= out_last_in;
      out_fill_ff  <= out_fill_in;
   end

endmodule

>>> tb/led_column_scroll_buffer_core_test.sv
module led_column_scroll_buffer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = lcsb_pkg::STORE_DEPTH_DEFAULT;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam logic [lcsb_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 8'd2;

   typedef struct packed {
      lcsb_pkg::op_type                                       op;
      lcsb_pkg::column_type                                   rx_byte;
      lcsb_pkg::column_type [lcsb_pkg::WINDOW_COLUMNS-1:0]    glyph;
   } glyph_req_type;

   typedef struct packed {
      logic [lcsb_pkg::DIGIT_W-1:0] digit_index;
      lcsb_pkg::column_type         column_bits;
      logic                         last;
      logic [lcsb_pkg::FILL_W-1:0]  fill_level;
   } frame_beat_type;

   class frame_scoreboard;
      lcsb_pkg::column_type columns [DEPTH];
      int                   head;
      int                   count;
      int                   period;
      int                   tick_cnt;
      int                   threshold;
      int                   speed_base;
      int                   failures;
      frame_beat_type       expected_beats [$];

      function new();
         head       = 0;
         count      = 0;
         period     = int'(lcsb_pkg::SPEED_RESET);
         tick_cnt   = 0;
         threshold  = int'(lcsb_pkg::THRESHOLD_RESET);
         speed_base = int'(lcsb_pkg::SPEED_RESET);
         failures   = 0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void note_config(logic [lcsb_pkg::CSR_INDEX_W-1:0] idx,
                                logic [lcsb_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            lcsb_pkg::REG_CHAR_THRESHOLD: threshold = int'(value);
            lcsb_pkg::REG_SPEED_BASE:     speed_base = int'(value[lcsb_pkg::SPEED_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_input(glyph_req_type it);
         frame_beat_type beat;
         if (it.op == lcsb_pkg::OP_BYTE) begin
            if (int'(it.rx_byte) >= threshold) begin
               if (count + lcsb_pkg::WINDOW_COLUMNS <= DEPTH) begin
                  for (int i = 0; i < lcsb_pkg::WINDOW_COLUMNS; i++)
                     columns[(head + count + i) % DEPTH] = it.glyph[i];
                  count += lcsb_pkg::WINDOW_COLUMNS;
               end
            end else begin
               period = (speed_base > int'(it.rx_byte)) ? speed_base - int'(it.rx_byte) : 0;
            end
         end else if (tick_cnt >= period) begin
            tick_cnt = 0;
            for (int i = 0; i < lcsb_pkg::WINDOW_COLUMNS; i++) begin
               beat.digit_index = lcsb_pkg::DIGIT_W'(i + 1);
               beat.column_bits = (i < count) ? columns[(head + i) % DEPTH]
                                              : lcsb_pkg::BLANK_COLUMN;
               beat.last        = (i == lcsb_pkg::WINDOW_COLUMNS - 1);
               beat.fill_level  = lcsb_pkg::FILL_W'(count);
               expected_beats.push_back(beat);
            end
            if (count > 0) begin
               head = (head + 1) % DEPTH;
               count--;
            end
         end else begin
            tick_cnt = (tick_cnt + 1) % 16;
         end
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(frame_beat_type got);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("rsp beat with nothing expected: digit_index %0d column_bits %0h",
                   got.digit_index, got.column_bits);
            failures++;
            return;
         end
         want = expected_beats.pop_front();
         compare("digit_index", 32'(want.digit_index), 32'(got.digit_index));
         compare("column_bits", 32'(want.column_bits), 32'(got.column_bits));
         compare("last", 32'(want.last), 32'(got.last));
         compare("fill_level", 32'(want.fill_level), 32'(got.fill_level));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   req_idle_pct  = 0;
   int   rsp_stall_pct = 0;
   int   hold_requests = 0;

   frame_scoreboard sb = new();

   lcsb_req_if req_bus();
   lcsb_rsp_if rsp_bus();
   lcsb_csr_if csr_bus();

   led_column_scroll_buffer_core #(
      .STORE_DEPTH(DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result({rsp_bus.digit_index, rsp_bus.column_bits, rsp_bus.last,
                          rsp_bus.fill_level});
   end

   initial begin
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic glyph_req_type fixed_item(lcsb_pkg::op_type op,
                                                lcsb_pkg::column_type rx,
                                                logic [63:0] glyphs);
      glyph_req_type it;
      it.op = op;
      it.rx_byte = rx;
      it.glyph = glyphs;
      return it;
   endfunction

   function automatic glyph_req_type random_item(int tick_pct, int char_pct);
      glyph_req_type it;
      int thr;
      int top;
      thr = sb.threshold;
      it.glyph = {$urandom(), $urandom()};
      it.rx_byte = 8'($urandom_range(255));
      it.op = lcsb_pkg::OP_BYTE;
      if ($urandom_range(99) < tick_pct) begin
         it.op = lcsb_pkg::OP_TICK;
      end else if ($urandom_range(99) < 10) begin
         // raw byte, either kind
      end else if (thr == 0 || $urandom_range(99) < char_pct) begin
         it.rx_byte = 8'($urandom_range(255, thr));
      end else begin
         top = (sb.speed_base < thr - 1) ? sb.speed_base : thr - 1;
         if ($urandom_range(1) == 0)
            it.rx_byte = 8'($urandom_range(top, 0));
         else
            it.rx_byte = 8'($urandom_range(thr - 1, 0));
      end
      return it;
   endfunction

   task automatic send_item(glyph_req_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= it.op;
      req_bus.rx_byte    <= it.rx_byte;
      req_bus.glyph_col0 <= it.glyph[0];
      req_bus.glyph_col1 <= it.glyph[1];
      req_bus.glyph_col2 <= it.glyph[2];
      req_bus.glyph_col3 <= it.glyph[3];
      req_bus.glyph_col4 <= it.glyph[4];
      req_bus.glyph_col5 <= it.glyph[5];
      req_bus.glyph_col6 <= it.glyph[6];
      req_bus.glyph_col7 <= it.glyph[7];
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(it);
   endtask

   task automatic write_reg(logic [lcsb_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lcsb_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.note_config(idx, value);
   endtask

   task automatic set_config(lcsb_pkg::column_type thr, logic [lcsb_pkg::SPEED_W-1:0] base);
      write_reg(lcsb_pkg::REG_CHAR_THRESHOLD, thr);
      write_reg(lcsb_pkg::REG_SPEED_BASE, {4'($urandom_range(15)), base});
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int n, int tick_pct, int char_pct, int idle_pct, int stall_pct);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < n; k++)
         send_item(random_item(tick_pct, char_pct));
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.op         <= lcsb_pkg::OP_BYTE;
      req_bus.rx_byte    <= '0;
      req_bus.glyph_col0 <= '0;
      req_bus.glyph_col1 <= '0;
      req_bus.glyph_col2 <= '0;
      req_bus.glyph_col3 <= '0;
      req_bus.glyph_col4 <= '0;
      req_bus.glyph_col5 <= '0;
      req_bus.glyph_col6 <= '0;
      req_bus.glyph_col7 <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: threshold 20, base 15, period 15
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd19, 64'hFFFF_FFFF_FFFF_FFFF));  // saturates to 0
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));  // empty frame
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd20, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd200, 64'h8040_2010_0804_0201));
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd14, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd0, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd15, 64'h0));  // counter above new period
      repeat (6) send_item(fixed_item(lcsb_pkg::OP_TICK, 8'h00, 64'h0));
      req_bus.valid <= 1'b0;
      wait_drained();

      // every byte a character: fill the store to the brim, then drain
      set_config(8'd0, 4'd0);
      req_idle_pct = 87;
      rsp_stall_pct = 0;
      run_phase(31, 0, 0, 87, 0);
      run_phase(14, 50, 0, 87, 0);
      wait_drained();

      set_config(8'd255, 4'd15);
      run_phase(40, 80, 50, 0, 87);
      wait_drained();

      set_config(8'd128, 4'd7);
      write_reg(REG_UNMAPPED, 8'hFF);
      csr_bus.valid <= 1'b0;
      run_phase(35, 60, 20, 32, 32);
      wait_drained();

      set_config(8'd20, 4'd15);
      run_phase(25, 55, 15, 0, 0);
      wait_drained();

      // long rsp hold-off while req keeps coming
      set_config(8'd20, 4'd3);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(fixed_item(lcsb_pkg::OP_BYTE, 8'd19, 64'h0));
      hold_requests++;
      run_phase(31, 85, 10, 0, 0);
      wait_drained();

      if (sb.failures == 0 && sb.pending() == 0)
         $display("led_column_scroll_buffer_core_test OK");
      else
         $display("led_column_scroll_buffer_core_test NOT OK");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("led_column_scroll_buffer_core_test NOT OK");
      $finish;
   end

endmodule
